@@ hdl/srt_pkg.sv @@
// Shared types and codes for the sorted top-records table.
// Holds the command and result beat structs and the operation codes.
// No dependencies.
package srt_pkg;

  localparam int DEFAULT_DEPTH     = 8;
  localparam int DEFAULT_KEY_WIDTH = 32;
  localparam int TAG_W             = 8;
  localparam int PORT_KEY_W        = 32;

  localparam logic [1:0] KIND_INSERT = 2'd0;
  localparam logic [1:0] KIND_READ   = 2'd1;
  localparam logic [1:0] KIND_CLEAR  = 2'd2;

  typedef struct packed {
    logic [1:0]            kind;
    logic [PORT_KEY_W-1:0] key_value;
    logic [TAG_W-1:0]      tag_value;
    logic                  flag_value;
    logic [2:0]            read_index;
  } command_t;

  typedef struct packed {
    logic                  accepted;
    logic [3:0]            position;
    logic [3:0]            entry_count;
    logic                  read_valid;
    logic [PORT_KEY_W-1:0] read_key;
    logic [TAG_W-1:0]      read_tag;
    logic                  read_flag;
  } result_t;

endpackage

@@ hdl/srt_cell.sv @@
// One entry of the sorted table: compares the incoming key and either keeps,
// takes the new record or takes its upper neighbor's record. Uses srt_pkg.
module srt_cell #(
  parameter int KeyWidth = srt_pkg::DEFAULT_KEY_WIDTH
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     clr,
  input  logic                     insert,
  input  logic [KeyWidth-1:0]      new_key,
  input  logic [srt_pkg::TAG_W-1:0] new_tag,
  input  logic                     new_flag,
  input  logic                     prev_ins,
  input  logic                     prev_valid,
  input  logic [KeyWidth-1:0]      prev_key,
  input  logic [srt_pkg::TAG_W-1:0] prev_tag,
  input  logic                     prev_flag,
  output logic                     ins,
  output logic                     valid,
  output logic [KeyWidth-1:0]      key,
  output logic [srt_pkg::TAG_W-1:0] tag,
  output logic                     flag
);
  import srt_pkg::*;

  assign ins = !valid || (new_key > key);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (clr) begin
      valid <= 1'b0;
    end else if (insert) begin
      if (prev_ins) begin
        valid <= prev_valid;
      end else if (ins) begin
        valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (insert) begin
      if (prev_ins) begin
        key  <= prev_key;
        tag  <= prev_tag;
        flag <= prev_flag;
      end else if (ins) begin
        key  <= new_key;
        tag  <= new_tag;
        flag <= new_flag;
      end
    end
  end

endmodule

@@ hdl/sorted_top_records_table.sv @@
// Top level of the sorted top-records table: a row of srt_cell entries,
// the entry counter and the registered result beat. Uses srt_pkg.
//
//   channel  | handshake          | payload
//   command  | start, busy        | command (srt_pkg::command_t)
//   result   | done               | result  (srt_pkg::result_t)
//
// Busy stays low, so a command beat may follow in every cycle; all cells
// compare and shift in parallel in the cycle of that beat. The result beat
// appears with done in the cycle after its command beat.
// Synchronous reset empties the table; the receiver cannot stall results.
module sorted_top_records_table #(
  parameter int Depth    = srt_pkg::DEFAULT_DEPTH,
  parameter int KeyWidth = srt_pkg::DEFAULT_KEY_WIDTH
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  srt_pkg::command_t command,
  output logic              done,
  output srt_pkg::result_t  result
);
  import srt_pkg::*;

  localparam int CountW   = $clog2(Depth + 1);
  localparam int ReadSpan = (Depth < 8) ? Depth : 8;

  logic                  beat;
  logic                  do_insert;
  logic                  do_clear;
  logic [KeyWidth-1:0]   new_key;
  logic [Depth-1:0]      ins_vec;
  logic [Depth-1:0]      valid_vec;
  logic [KeyWidth-1:0]   cell_key [Depth];
  logic [TAG_W-1:0]      cell_tag [Depth];
  logic [Depth-1:0]      cell_flag;
  logic [CountW-1:0]     count;
  logic [CountW-1:0]     count_next;
  logic                  last_accepted;
  logic                  last_accepted_next;
  logic [CountW-1:0]     ins_pos;
  logic                  ins_ok;
  logic                  rd_valid;
  logic [KeyWidth-1:0]   rd_key;
  logic [TAG_W-1:0]      rd_tag;
  logic                  rd_flag;
  result_t               result_next;

  assign busy      = 1'b0;
  assign beat      = start && !busy;
  assign do_insert = beat && (command.kind == KIND_INSERT);
  assign do_clear  = beat && (command.kind == KIND_CLEAR);
  assign new_key   = KeyWidth'(command.key_value);

  for (genvar i = 0; i < Depth; i++) begin : g_cell
    logic                prev_ins;
    logic                prev_valid;
    logic [KeyWidth-1:0] prev_key;
    logic [TAG_W-1:0]    prev_tag;
    logic                prev_flag;

    if (i == 0) begin : g_head
      assign prev_ins   = 1'b0;
      assign prev_valid = 1'b0;
      assign prev_key   = '0;
      assign prev_tag   = '0;
      assign prev_flag  = 1'b0;
    end else begin : g_body
      assign prev_ins   = ins_vec[i-1];
      assign prev_valid = valid_vec[i-1];
      assign prev_key   = cell_key[i-1];
      assign prev_tag   = cell_tag[i-1];
      assign prev_flag  = cell_flag[i-1];
    end

    srt_cell #(
      .KeyWidth (KeyWidth)
    ) u_cell (
      .clk        (clk),
      .rst        (rst),
      .clr        (do_clear),
      .insert     (do_insert),
      .new_key    (new_key),
      .new_tag    (command.tag_value),
      .new_flag   (command.flag_value),
      .prev_ins   (prev_ins),
      .prev_valid (prev_valid),
      .prev_key   (prev_key),
      .prev_tag   (prev_tag),
      .prev_flag  (prev_flag),
      .ins        (ins_vec[i]),
      .valid      (valid_vec[i]),
      .key        (cell_key[i]),
      .tag        (cell_tag[i]),
      .flag       (cell_flag[i])
    );
  end

  always_comb begin
    ins_pos = CountW'(Depth);
    for (int i = Depth - 1; i >= 0; i--) begin
      if (ins_vec[i]) begin
        ins_pos = CountW'(i);
      end
    end
  end

  assign ins_ok = |ins_vec;

  always_comb begin
    rd_key  = '0;
    rd_tag  = '0;
    rd_flag = 1'b0;
    for (int i = 0; i < ReadSpan; i++) begin
      if (command.read_index == 3'(i)) begin
        rd_key  = cell_key[i];
        rd_tag  = cell_tag[i];
        rd_flag = cell_flag[i];
      end
    end
  end

  assign rd_valid = ({{CountW{1'b0}}, command.read_index} < {3'b000, count})
                    && (32'(command.read_index) < 32'(Depth));

  always_comb begin
    count_next         = count;
    last_accepted_next = last_accepted;
    result_next             = '0;
    result_next.accepted    = last_accepted;
    result_next.position    = 4'(Depth);
    unique case (command.kind)
      KIND_INSERT: begin
        last_accepted_next   = ins_ok;
        result_next.accepted = ins_ok;
        if (ins_ok) begin
          result_next.position = 4'(ins_pos);
          if (count != CountW'(Depth)) begin
            count_next = count + CountW'(1);
          end
        end
      end
      KIND_READ: begin
        if (rd_valid) begin
          result_next.read_valid = 1'b1;
          result_next.read_key   = PORT_KEY_W'(rd_key);
          result_next.read_tag   = rd_tag;
          result_next.read_flag  = rd_flag;
        end
      end
      KIND_CLEAR: begin
        count_next           = '0;
        last_accepted_next   = 1'b0;
        result_next.accepted = 1'b0;
      end
      default: begin
      end
    endcase
    result_next.entry_count = 4'(count_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count         <= '0;
      last_accepted <= 1'b0;
      done          <= 1'b0;
    end else begin
      done <= beat;
      if (beat) begin
        count         <= count_next;
        last_accepted <= last_accepted_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (beat) begin
      result <= result_next;
    end
  end

`ifndef SYNTHESIS
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CountW'(Depth))
    else $error("entry count beyond table depth");

  a_valid_prefix: assert property (@(posedge clk) disable iff (rst)
    $onehot({1'b0, valid_vec} + {{Depth{1'b0}}, 1'b1}))
    else $error("valid entries do not form a prefix");

  a_count_matches: assert property (@(posedge clk) disable iff (rst)
    $countones(valid_vec) == int'(count))
    else $error("entry count disagrees with valid cells");

  a_done_after_beat: assert property (@(posedge clk) disable iff (rst)
    beat |=> done)
    else $error("command beat without result beat");

  a_clear_empties: assert property (@(posedge clk) disable iff (rst)
    do_clear |=> (count == '0) && (valid_vec == '0))
    else $error("clear left entries behind");
`endif

endmodule

@@ sim/tb.sv @@
// Testbench for sorted_top_records_table: directed and random command beats
// checked against an in-bench model of the sorted table. Uses srt_pkg.
`timescale 1ns / 1ps

module tb;
  import srt_pkg::*;

  localparam int DEPTH = DEFAULT_DEPTH;
  localparam logic [1:0] KIND_UNUSED = 2'd3;

  logic clk;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  command_t command = '0;
  logic done;
  result_t result;

  logic [PORT_KEY_W-1:0] held_key [DEPTH];
  logic [TAG_W-1:0] held_tag [DEPTH];
  logic held_flag [DEPTH];
  int held_count;
  logic held_accepted;

  result_t pending_results[$];
  result_t expected_beat;
  int errors = 0;

  sorted_top_records_table u_dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .command(command),
    .done(done),
    .result(result)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("Verification failed");
    $finish;
  end

  function automatic result_t apply_command(command_t c);
    result_t r;
    int at;
    r = '0;
    r.accepted = held_accepted;
    r.position = 4'(DEPTH);
    case (c.kind)
      KIND_INSERT: begin
        at = held_count;
        for (int i = 0; i < held_count; i++) begin
          if (at == held_count && c.key_value > held_key[i]) at = i;
        end
        if (at >= DEPTH) begin
          held_accepted = 1'b0;
          r.accepted = 1'b0;
        end else begin
          if (held_count < DEPTH) held_count++;
          for (int i = held_count - 1; i > at; i--) begin
            held_key[i] = held_key[i-1];
            held_tag[i] = held_tag[i-1];
            held_flag[i] = held_flag[i-1];
          end
          held_key[at] = c.key_value;
          held_tag[at] = c.tag_value;
          held_flag[at] = c.flag_value;
          held_accepted = 1'b1;
          r.accepted = 1'b1;
          r.position = 4'(at);
        end
      end
      KIND_READ: begin
        if (int'(c.read_index) < held_count) begin
          r.read_valid = 1'b1;
          r.read_key = held_key[c.read_index];
          r.read_tag = held_tag[c.read_index];
          r.read_flag = held_flag[c.read_index];
        end
      end
      KIND_CLEAR: begin
        for (int i = 0; i < DEPTH; i++) begin
          held_key[i] = '0;
          held_tag[i] = '0;
          held_flag[i] = 1'b0;
        end
        held_count = 0;
        held_accepted = 1'b0;
        r.accepted = 1'b0;
      end
      default: begin
      end
    endcase
    r.entry_count = 4'(held_count);
    return r;
  endfunction

  function automatic command_t make_command(logic [1:0] kind, logic [31:0] key,
                                            logic [7:0] tag, logic flag, logic [2:0] idx);
    command_t c;
    c.kind = kind;
    c.key_value = key;
    c.tag_value = tag;
    c.flag_value = flag;
    c.read_index = idx;
    return c;
  endfunction

  function automatic command_t random_command();
    return make_command(2'($urandom), $urandom, 8'($urandom), 1'($urandom), 3'($urandom));
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  task automatic send_command(command_t c, int gap);
    start <= 1'b1;
    command <= c;
    do @(posedge clk); while (busy);
    pending_results.push_back(apply_command(c));
    if (gap > 0) begin
      start <= 1'b0;
      command <= random_command();
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst && done) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result beat, expected none, actual %0h", $time, result);
        errors++;
      end else begin
        expected_beat = pending_results.pop_front();
        check_field("accepted", 32'(expected_beat.accepted), 32'(result.accepted));
        check_field("position", 32'(expected_beat.position), 32'(result.position));
        check_field("entry_count", 32'(expected_beat.entry_count), 32'(result.entry_count));
        check_field("read_valid", 32'(expected_beat.read_valid), 32'(result.read_valid));
        check_field("read_key", expected_beat.read_key, result.read_key);
        check_field("read_tag", 32'(expected_beat.read_tag), 32'(result.read_tag));
        check_field("read_flag", 32'(expected_beat.read_flag), 32'(result.read_flag));
      end
    end
  end

  task automatic test_empty_table();
    send_command(make_command(KIND_READ, 32'hFFFF_FFFF, 8'hFF, 1'b1, 3'd0), pick_gap());
    send_command(make_command(KIND_READ, '0, '0, 1'b0, 3'd7), pick_gap());
    send_command(make_command(KIND_UNUSED, 32'h1234_5678, 8'h5A, 1'b1, 3'd0), pick_gap());
  endtask

  task automatic test_ordering_and_ties();
    send_command(make_command(KIND_INSERT, 32'h0, 8'hFF, 1'b1, 3'd7), pick_gap());
    send_command(make_command(KIND_INSERT, 32'hFFFF_FFFF, 8'h00, 1'b0, 3'd0), pick_gap());
    send_command(make_command(KIND_INSERT, 32'd5, 8'h0A, 1'b0, 3'd0), pick_gap());
    send_command(make_command(KIND_INSERT, 32'd5, 8'h0B, 1'b1, 3'd0), pick_gap());
    send_command(make_command(KIND_INSERT, 32'd5, 8'h0C, 1'b0, 3'd0), pick_gap());
    send_command(make_command(KIND_INSERT, 32'd1, 8'h11, 1'b1, 3'd0), pick_gap());
    send_command(make_command(KIND_INSERT, 32'd100, 8'h64, 1'b0, 3'd0), pick_gap());
    send_command(make_command(KIND_INSERT, 32'd2, 8'h22, 1'b1, 3'd0), pick_gap());
    send_command(make_command(KIND_READ, '0, '0, 1'b0, 3'd2), pick_gap());
    send_command(make_command(KIND_READ, '0, '0, 1'b0, 3'd3), pick_gap());
    send_command(make_command(KIND_READ, '0, '0, 1'b0, 3'd4), pick_gap());
  endtask

  task automatic test_full_table();
    send_command(make_command(KIND_INSERT, 32'h0, 8'hEE, 1'b1, 3'd0), pick_gap());
    send_command(make_command(KIND_UNUSED, 32'hFFFF_FFFF, 8'hFF, 1'b1, 3'd7), pick_gap());
    send_command(make_command(KIND_INSERT, 32'd3, 8'h33, 1'b1, 3'd0), pick_gap());
    send_command(make_command(KIND_READ, '0, '0, 1'b0, 3'd7), pick_gap());
    send_command(make_command(KIND_READ, '0, '0, 1'b0, 3'd0), pick_gap());
  endtask

  task automatic test_clear();
    send_command(make_command(KIND_CLEAR, 32'hFFFF_FFFF, 8'hFF, 1'b1, 3'd7), pick_gap());
    send_command(make_command(KIND_READ, '0, '0, 1'b0, 3'd0), pick_gap());
    send_command(make_command(KIND_INSERT, 32'h0, 8'h01, 1'b0, 3'd0), pick_gap());
    send_command(make_command(KIND_READ, '0, '0, 1'b0, 3'd0), pick_gap());
  endtask

  task automatic test_random_traffic(int item_total);
    int sent;
    int span;
    int key_mode;
    int r;
    bit no_idle;
    command_t c;
    sent = 0;
    while (sent < item_total) begin
      span = $urandom_range(10, 60);
      key_mode = $urandom_range(0, 3);
      no_idle = ($urandom_range(0, 3) == 0);
      for (int n = 0; n < span && sent < item_total; n++) begin
        c = random_command();
        r = $urandom_range(0, 99);
        if (r < 55) c.kind = KIND_INSERT;
        else if (r < 96) c.kind = KIND_READ;
        else if (r < 98) c.kind = KIND_UNUSED;
        else c.kind = KIND_CLEAR;
        case (key_mode)
          1: c.key_value = $urandom_range(0, 15);
          2: c.key_value = 32'hFFFF_FFF0 + $urandom_range(0, 15);
          3: begin
            r = $urandom_range(0, 2);
            c.key_value = (r == 0) ? 32'h0 : (r == 1) ? 32'hFFFF_FFFF : $urandom;
          end
          default: c.key_value = $urandom;
        endcase
        send_command(c, no_idle ? 0 : pick_gap());
        sent++;
      end
      if ($urandom_range(0, 1) == 0 && sent < item_total) begin
        c = random_command();
        c.kind = KIND_CLEAR;
        send_command(c, no_idle ? 0 : pick_gap());
        sent++;
      end
    end
  endtask

  initial begin
    int wait_cycles;
    for (int i = 0; i < DEPTH; i++) begin
      held_key[i] = '0;
      held_tag[i] = '0;
      held_flag[i] = 1'b0;
    end
    held_count = 0;
    held_accepted = 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    test_empty_table();
    test_ordering_and_ties();
    test_full_table();
    test_clear();
    test_random_traffic(630);
    start <= 1'b0;
    wait_cycles = 0;
    while (pending_results.size() != 0 && wait_cycles < 100) begin
      @(posedge clk);
      wait_cycles++;
    end
    if (pending_results.size() != 0) begin
      $display("%0t: %0d result beats never arrived, expected %0h, actual none",
               $time, pending_results.size(), pending_results[0]);
      errors++;
    end
    repeat (4) @(posedge clk);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
